// ===== hw/rtl/http_cl_pkg.sv =====
// http_cl_pkg: item types, parse phase codes and character constants
// for the content-length extractor; no dependencies

package http_cl_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        headers_complete;
		logic        length_found;
		logic [31:0] length_value;
	} res_item_t;

	localparam logic [2:0] PH_START      = 3'd0;
	localparam logic [2:0] PH_LINE_BEGIN = 3'd1;
	localparam logic [2:0] PH_NAME       = 3'd2;
	localparam logic [2:0] PH_SKIP_WS    = 3'd3;
	localparam logic [2:0] PH_DIGITS     = 3'd4;
	localparam logic [2:0] PH_REST       = 3'd5;

	localparam logic [3:0] KEY_LEN = 4'd14;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// lower-case "content-length"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:  c = 8'h63;
			4'd1:  c = 8'h6f;
			4'd2:  c = 8'h6e;
			4'd3:  c = 8'h74;
			4'd4:  c = 8'h65;
			4'd5:  c = 8'h6e;
			4'd6:  c = 8'h74;
			4'd7:  c = 8'h2d;
			4'd8:  c = 8'h6c;
			4'd9:  c = 8'h65;
			4'd10: c = 8'h6e;
			4'd11: c = 8'h67;
			4'd12: c = 8'h74;
			4'd13: c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/http_cl_if.sv =====
// http_cl_if: valid/ready channel carrying one item of a given type
// depends on nothing; item types come from http_cl_pkg at instantiation

interface http_cl_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/http_content_length_extractor_top.sv =====
// http_content_length_extractor_top: byte-wise HTTP header parser that reports
// the content-length value; depends on http_cl_pkg and http_cl_if
//
// usage
//   msg: one byte of the message per item (data_byte, last_byte marks the end)
//   rsp: at most one result item per message, given when an empty line ends
//     the header block or, failing that, with the last byte of the message
//   path: an accepted byte waits in the input register; its result, if any, is
//     written to the output register, which drives rsp
//   throughput: one byte per cycle while no result waits (see stall); the parse
//     state is updated in the same cycle a byte leaves the input register, so a
//     byte can follow in the next cycle
//   stall: the output register holds a waiting result; bytes that give no
//     result keep flowing past it, and a byte that would give one waits in
//     the input register, which then drops msg.ready
//   reset: arst_n clears the parse state to the start-line phase and empties
//     both registers; the byte after a last_byte starts a new message

module http_content_length_extractor_top #(
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	http_cl_if.sink msg,
	http_cl_if.source rsp
);

	localparam int WB = LENGTH_BITS + 4;

	typedef struct packed {
		logic [2:0]             phase;
		logic                   prior_cr;
		logic [3:0]             pos;
		logic                   match;
		logic [LENGTH_BITS-1:0] acc;
		logic                   seen;
		logic                   ovf;
		logic                   found;
		logic [LENGTH_BITS-1:0] stored;
		logic                   given;
	} parse_t;

	localparam parse_t ST_RESET = '{
		phase:    http_cl_pkg::PH_START,
		prior_cr: 1'b0,
		pos:      4'd0,
		match:    1'b1,
		acc:      '0,
		seen:     1'b0,
		ovf:      1'b0,
		found:    1'b0,
		stored:   '0,
		given:    1'b0
	};

	function automatic parse_t commit(input parse_t s);
		parse_t n;
		n = s;
		if (s.seen && !s.ovf) begin
			n.found  = 1'b1;
			n.stored = s.acc;
		end
		return n;
	endfunction

	function automatic parse_t take_digit(input parse_t s, input logic [7:0] b);
		parse_t n;
		logic [WB-1:0] wide;
		n = s;
		wide = WB'(s.acc) * WB'(10) + WB'(b[3:0]);
		n.seen = 1'b1;
		if (!s.ovf) begin
			if (wide[WB-1:LENGTH_BITS] != '0)
				n.ovf = 1'b1;
			else
				n.acc = wide[LENGTH_BITS-1:0];
		end
		return n;
	endfunction

	function automatic parse_t content_byte(input parse_t s, input logic [7:0] b);
		parse_t n;
		logic [7:0] low;
		logic is_digit;
		n = s;
		low = (b >= http_cl_pkg::CH_UP_A && b <= http_cl_pkg::CH_UP_Z) ?
			b + http_cl_pkg::CASE_GAP : b;
		is_digit = (b >= http_cl_pkg::CH_ZERO) && (b <= http_cl_pkg::CH_NINE);
		if (n.phase == http_cl_pkg::PH_LINE_BEGIN) begin
			n.phase = http_cl_pkg::PH_NAME;
			n.pos   = 4'd0;
			n.match = 1'b1;
		end
		case (n.phase)
			http_cl_pkg::PH_NAME: begin
				if (b == http_cl_pkg::CH_COLON) begin
					if (n.match && n.pos == http_cl_pkg::KEY_LEN) begin
						n.phase = http_cl_pkg::PH_SKIP_WS;
						n.acc   = '0;
						n.seen  = 1'b0;
						n.ovf   = 1'b0;
					end else begin
						n.phase = http_cl_pkg::PH_REST;
					end
				end else if (n.match && n.pos < http_cl_pkg::KEY_LEN &&
						low == http_cl_pkg::key_char(n.pos)) begin
					n.pos = n.pos + 4'd1;
				end else begin
					n.match = 1'b0;
				end
			end
			http_cl_pkg::PH_SKIP_WS: begin
				if (b == http_cl_pkg::CH_SPACE || b == http_cl_pkg::CH_TAB) begin
					n.phase = http_cl_pkg::PH_SKIP_WS;
				end else if (!is_digit) begin
					n.phase = http_cl_pkg::PH_REST;
				end else begin
					n = take_digit(n, b);
					n.phase = http_cl_pkg::PH_DIGITS;
				end
			end
			http_cl_pkg::PH_DIGITS: begin
				if (is_digit) begin
					n = take_digit(n, b);
				end else begin
					n = commit(n);
					n.phase = http_cl_pkg::PH_REST;
				end
			end
			default: begin
				n.phase = n.phase;
			end
		endcase
		return n;
	endfunction

	logic                  valid_s1;
	http_cl_pkg::in_item_t item_s1;
	parse_t                state_q;
	parse_t                state_d;
	logic                  rsp_valid_q;
	http_cl_pkg::res_item_t rsp_q;
	http_cl_pkg::res_item_t res_d;
	logic                  done;
	logic                  produce;
	logic                  out_free;
	logic                  advance;
	logic [LENGTH_BITS+31:0] len_ext;

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		if (!state_q.given) begin
			if (state_q.prior_cr) begin
				state_d.prior_cr = 1'b0;
				if (item_s1.data_byte == http_cl_pkg::CH_LF) begin
					if (state_d.phase == http_cl_pkg::PH_LINE_BEGIN) begin
						done = 1'b1;
					end else begin
						if (state_d.phase == http_cl_pkg::PH_DIGITS)
							state_d = commit(state_d);
						state_d.phase = http_cl_pkg::PH_LINE_BEGIN;
					end
				end else begin
					state_d = content_byte(state_d, http_cl_pkg::CH_CR);
					if (item_s1.data_byte == http_cl_pkg::CH_CR)
						state_d.prior_cr = 1'b1;
					else
						state_d = content_byte(state_d, item_s1.data_byte);
				end
			end else if (item_s1.data_byte == http_cl_pkg::CH_CR) begin
				state_d.prior_cr = 1'b1;
			end else begin
				state_d = content_byte(state_d, item_s1.data_byte);
			end
		end
		len_ext = (LENGTH_BITS + 32)'(state_d.stored);
		res_d.headers_complete = done;
		res_d.length_found     = done && state_d.found;
		res_d.length_value     = (done && state_d.found) ? len_ext[31:0] : 32'd0;
		produce = !state_q.given && (done || item_s1.last_byte);
		if (done)
			state_d.given = 1'b1;
		if (item_s1.last_byte)
			state_d = ST_RESET;
	end

	assign out_free    = !rsp_valid_q || rsp.ready;
	assign advance     = valid_s1 && (!produce || out_free);
	assign msg.ready   = !valid_s1 || advance;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready)
			item_s1 <= msg.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && produce) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce)
			rsp_q <= res_d;
	end

endmodule

// ===== hw/rtl/http_cl_checker.sv =====
// http_cl_checker: port-level checks on the result channel of the extractor
// depends on http_content_length_extractor_top, to which it is bound

module http_cl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        headers_complete,
	input logic        length_found,
	input logic [31:0] length_value
);

	// result held while the receiver stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(headers_complete) &&
			$stable(length_found) && $stable(length_value))
		else $error("result changed during stall");

	// a length is only reported for a finished header block
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !headers_complete |-> !length_found)
		else $error("length reported without finished headers");

	// no length means a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !length_found |-> length_value == 32'd0)
		else $error("nonzero value without a length");

	// nothing offered while in reset
	assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result offered during reset");

endmodule

bind http_content_length_extractor_top http_cl_checker u_http_cl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.headers_complete (rsp.payload.headers_complete),
	.length_found     (rsp.payload.length_found),
	.length_value     (rsp.payload.length_value)
);

// ===== verif/tb_http_content_length_extractor_top.sv =====
// tb_http_content_length_extractor_top: self-checking bench that streams HTTP messages
// byte by byte and checks each content-length result against an in-bench header parser
// depends on http_cl_pkg, http_cl_if and http_content_length_extractor_top

module tb_http_content_length_extractor_top;

	localparam int LEN_BITS = 32;
	localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [8*14-1:0] CL_KEY = "content-length";

	logic clk = 1'b0;
	logic arst_n;

	http_cl_if #(.item_t(http_cl_pkg::in_item_t)) msg_ch ();
	http_cl_if #(.item_t(http_cl_pkg::res_item_t)) rsp_ch ();

	http_content_length_extractor_top #(.LENGTH_BITS(LEN_BITS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int error_count = 0;
	int cycle_count = 0;
	bit steady_flow = 1'b0;
	bit hold_req = 1'b0;
	bit hold_on = 1'b0;
	http_cl_pkg::res_item_t pending_lengths[$];
	logic [7:0] msg_text[$];

	// parser state mirrored in the bench
	logic [2:0] hdr_phase;
	bit cr_held;
	logic [3:0] key_pos;
	bit key_ok;
	longint unsigned digit_acc;
	bit digit_any;
	bit digit_ovf;
	bit cl_found;
	longint unsigned cl_value;
	bit answered;

	task automatic clear_parser();
		hdr_phase = http_cl_pkg::PH_START;
		cr_held = 1'b0;
		key_pos = '0;
		key_ok = 1'b1;
		digit_acc = 0;
		digit_any = 1'b0;
		digit_ovf = 1'b0;
		cl_found = 1'b0;
		cl_value = 0;
		answered = 1'b0;
	endtask

	task automatic keep_length();
		if (digit_any && !digit_ovf) begin
			cl_found = 1'b1;
			cl_value = digit_acc;
		end
	endtask

	task automatic add_digit(input logic [7:0] b);
		longint unsigned d;
		d = 64'(b) - 64'(http_cl_pkg::CH_ZERO);
		digit_any = 1'b1;
		if (!digit_ovf) begin
			if (digit_acc > (LEN_MAX - d) / 10)
				digit_ovf = 1'b1;
			else
				digit_acc = digit_acc * 10 + d;
		end
	endtask

	task automatic parse_content(input logic [7:0] b);
		logic [7:0] low;
		bit is_digit;
		is_digit = (b >= http_cl_pkg::CH_ZERO) && (b <= http_cl_pkg::CH_NINE);
		if (hdr_phase == http_cl_pkg::PH_LINE_BEGIN) begin
			hdr_phase = http_cl_pkg::PH_NAME;
			key_pos = '0;
			key_ok = 1'b1;
		end
		case (hdr_phase)
			http_cl_pkg::PH_NAME: begin
				if (b == http_cl_pkg::CH_COLON) begin
					if (key_ok && key_pos == http_cl_pkg::KEY_LEN) begin
						hdr_phase = http_cl_pkg::PH_SKIP_WS;
						digit_acc = 0;
						digit_any = 1'b0;
						digit_ovf = 1'b0;
					end else begin
						hdr_phase = http_cl_pkg::PH_REST;
					end
				end else begin
					low = (b >= http_cl_pkg::CH_UP_A && b <= http_cl_pkg::CH_UP_Z) ?
						b + http_cl_pkg::CASE_GAP : b;
					if (key_ok && key_pos < http_cl_pkg::KEY_LEN &&
					    low == CL_KEY[8*(13 - int'(key_pos)) +: 8])
						key_pos = key_pos + 4'd1;
					else
						key_ok = 1'b0;
				end
			end
			http_cl_pkg::PH_SKIP_WS: begin
				if (b == http_cl_pkg::CH_SPACE || b == http_cl_pkg::CH_TAB) begin
				end else if (!is_digit) begin
					hdr_phase = http_cl_pkg::PH_REST;
				end else begin
					hdr_phase = http_cl_pkg::PH_DIGITS;
					add_digit(b);
				end
			end
			http_cl_pkg::PH_DIGITS: begin
				if (is_digit) begin
					add_digit(b);
				end else begin
					keep_length();
					hdr_phase = http_cl_pkg::PH_REST;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic end_line(output bit closes);
		closes = 1'b0;
		if (hdr_phase == http_cl_pkg::PH_LINE_BEGIN)
			closes = 1'b1;
		else if (hdr_phase == http_cl_pkg::PH_DIGITS)
			keep_length();
		if (!closes)
			hdr_phase = http_cl_pkg::PH_LINE_BEGIN;
	endtask

	task automatic predict_length_result(input logic [7:0] b, input logic last);
		bit closes;
		http_cl_pkg::res_item_t r;
		closes = 1'b0;
		r = '0;
		if (!answered) begin
			if (cr_held) begin
				cr_held = 1'b0;
				if (b == http_cl_pkg::CH_LF) begin
					end_line(closes);
				end else begin
					parse_content(http_cl_pkg::CH_CR);
					if (b == http_cl_pkg::CH_CR)
						cr_held = 1'b1;
					else
						parse_content(b);
				end
			end else if (b == http_cl_pkg::CH_CR) begin
				cr_held = 1'b1;
			end else begin
				parse_content(b);
			end
			if (closes) begin
				r.headers_complete = 1'b1;
				r.length_found = cl_found;
				r.length_value = cl_found ? cl_value[31:0] : 32'd0;
				pending_lengths.push_back(r);
				answered = 1'b1;
			end else if (last) begin
				pending_lengths.push_back(r);
			end
		end
		if (last)
			clear_parser();
	endtask

	always @(posedge clk) begin : check_results
		http_cl_pkg::res_item_t want;
		http_cl_pkg::res_item_t got;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (pending_lengths.size() == 0) begin
					$error("result item with no expected result");
					error_count++;
				end else begin
					want = pending_lengths.pop_front();
					if (got.headers_complete !== want.headers_complete) begin
						$error("headers_complete expected %0d got %0d",
						       want.headers_complete, got.headers_complete);
						error_count++;
					end
					if (got.length_found !== want.length_found) begin
						$error("length_found expected %0d got %0d",
						       want.length_found, got.length_found);
						error_count++;
					end
					if (got.length_value !== want.length_value) begin
						$error("length_value expected %0d got %0d",
						       want.length_value, got.length_value);
						error_count++;
					end
				end
			end
			if (msg_ch.valid && msg_ch.ready)
				predict_length_result(msg_ch.payload.data_byte, msg_ch.payload.last_byte);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver side: random stalls, a long hold on request
	initial begin : result_sink
		int gap;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				hold_on = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_on = 1'b0;
				hold_req = 1'b0;
			end else if (steady_flow) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				gap = idle_len();
				if (gap == 0) begin
					rsp_ch.ready <= 1'b1;
				end else begin
					rsp_ch.ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = steady_flow ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			msg_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		msg_ch.valid <= 1'b1;
		msg_ch.payload <= '{data_byte: b, last_byte: last};
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_text.size(); i++)
			send_byte(msg_text[i], i == msg_text.size() - 1);
		msg_text.delete();
	endtask

	task automatic put_byte(input logic [7:0] b);
		msg_text.push_back(b);
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			msg_text.push_back(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(http_cl_pkg::CH_CR);
		put_byte(http_cl_pkg::CH_LF);
	endtask

	task automatic put_line(input string s);
		put_text(s);
		put_crlf();
	endtask

	task automatic test_basic_request();
		put_line("GET / HTTP/1.1");
		put_line("Host: a");
		put_line("Content-Length: 42");
		put_crlf();
		send_message();
		put_line("POST /x HTTP/1.1");
		put_line("cOnTeNt-LeNgTh:\t \t0077");
		put_crlf();
		put_text("body");
		send_message();
	endtask

	task automatic test_value_edges();
		put_line("GET");
		put_line("content-length: 4294967295");
		put_crlf();
		send_message();
		put_line("GET");
		put_line("content-length: 17");
		put_line("content-length: 4294967296");
		put_line("content-length: 99999999999999999999");
		put_crlf();
		send_message();
		put_line("GET");
		put_line("content-length: 1");
		put_line("content-length: 0");
		put_crlf();
		send_message();
		put_line("GET");
		put_line("Content-Length: 12abc");
		put_crlf();
		send_message();
	endtask

	task automatic test_bad_values();
		put_line("GET");
		put_line("content-length: +5");
		put_line("content-length: -5");
		put_line("content-length: 0x10");
		put_line("content-length:");
		put_line("content-length:  \t");
		put_line("content-length :5");
		put_line("xcontent-length:5");
		put_line("content-lengthx:5");
		put_line("content-length 5");
		put_crlf();
		send_message();
	endtask

	task automatic test_empty_block();
		put_line("GET");
		put_crlf();
		send_message();
		put_crlf();
		put_crlf();
		send_message();
	endtask

	task automatic test_unfinished();
		put_line("GET");
		put_line("content-length: 5");
		send_message();
		put_text("x");
		send_message();
		put_crlf();
		send_message();
		put_line("GET");
		put_text("content-length: 9");
		send_message();
		put_line("GET");
		put_byte(http_cl_pkg::CH_CR);
		send_message();
	endtask

	task automatic test_stray_cr();
		put_line("GET");
		put_text("content-length: 3");
		put_byte(http_cl_pkg::CH_CR);
		put_line("5");
		put_text("con");
		put_byte(http_cl_pkg::CH_CR);
		put_line("tent-length: 4");
		put_crlf();
		send_message();
		put_line("GET");
		put_text("content-length: 8");
		put_byte(http_cl_pkg::CH_CR);
		put_crlf();
		put_byte(http_cl_pkg::CH_CR);
		put_byte(http_cl_pkg::CH_CR);
		put_crlf();
		put_crlf();
		send_message();
	endtask

	task automatic test_extreme_bytes();
		put_byte(8'h00);
		put_byte(8'hff);
		put_crlf();
		put_text("content-length:");
		put_byte(8'h80);
		put_crlf();
		put_line("content-length: 255");
		put_crlf();
		put_byte(8'hff);
		put_byte(8'h00);
		send_message();
		put_byte(8'hff);
		send_message();
	endtask

	task automatic test_backpressure();
		int i;
		hold_req = 1'b1;
		wait (hold_on);
		steady_flow = 1'b1;
		for (i = 0; i < 8; i++) begin
			put_line("P");
			put_line("content-length: 7");
			put_crlf();
			send_message();
		end
		steady_flow = 1'b0;
	endtask

	task automatic put_length_value();
		longint unsigned big;
		case ($urandom_range(0, 11))
			0, 1, 2: put_text($sformatf("%0d", $urandom));
			3, 4: put_text($sformatf("%0d", $urandom_range(0, 999)));
			5: put_text($sformatf("000%0d", $urandom_range(0, 99)));
			6: put_text("4294967295");
			7: begin
				big = 64'h1_0000_0000 + $urandom_range(0, 99999);
				put_text($sformatf("%0d", big));
			end
			8: put_text($sformatf("%0d%0d", $urandom_range(1, 99999), $urandom));
			9: begin
			end
			10: begin
				case ($urandom_range(0, 3))
					0: put_byte("+");
					1: put_byte("-");
					2: put_byte("x");
					default: put_byte(http_cl_pkg::CH_COLON);
				endcase
				put_text($sformatf("%0d", $urandom_range(0, 999)));
			end
			default: put_text($sformatf("%0d;q", $urandom_range(0, 99999)));
		endcase
	endtask

	task automatic add_random_header();
		int kind;
		int i;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			put_line("content-length 12");
			return;
		end
		if (kind <= 5) begin
			for (i = 0; i < 14; i++) begin
				c = CL_KEY[8*(13 - i) +: 8];
				if ($urandom_range(0, 1) && c >= "a" && c <= "z")
					c = c - http_cl_pkg::CASE_GAP;
				put_byte(c);
			end
		end else if (kind == 6) begin
			case ($urandom_range(0, 3))
				0: put_text("content-lengt");
				1: put_text("content-lengthh");
				2: put_text("content_length");
				default: put_text(" content-length");
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: put_text("Host");
				1: put_text("Accept");
				2: put_text("Content-Type");
				default: put_text("x");
			endcase
		end
		put_byte(http_cl_pkg::CH_COLON);
		repeat ($urandom_range(0, 3))
			put_byte($urandom_range(0, 1) ? http_cl_pkg::CH_SPACE : http_cl_pkg::CH_TAB);
		put_length_value();
		if ($urandom_range(0, 9) == 0)
			put_byte(http_cl_pkg::CH_CR);
		put_crlf();
	endtask

	task automatic build_request();
		int r;
		repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(8'h21, 8'h7e)));
		if ($urandom_range(0, 19) == 0)
			put_byte(http_cl_pkg::CH_CR);
		put_crlf();
		repeat ($urandom_range(0, 4)) add_random_header();
		r = $urandom_range(0, 19);
		if (r < 16) begin
			put_crlf();
			repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
		end else if (r >= 18) begin
			put_text($sformatf("content-length: %0d", $urandom_range(0, 999)));
		end
	endtask

	task automatic build_noise();
		repeat ($urandom_range(1, 16)) begin
			case ($urandom_range(0, 9))
				0: put_byte(http_cl_pkg::CH_CR);
				1: put_byte(http_cl_pkg::CH_LF);
				2: put_byte(http_cl_pkg::CH_COLON);
				default: put_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic test_random_messages();
		int n_msg;
		int n_bytes;
		n_msg = 0;
		n_bytes = 0;
		while (n_bytes < 390) begin
			steady_flow = (n_msg % 6) >= 4;
			if ($urandom_range(0, 9) == 0)
				build_noise();
			else
				build_request();
			n_bytes += msg_text.size();
			send_message();
			n_msg++;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n = 1'b1;
		msg_ch.valid = 1'b0;
		msg_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		clear_parser();
		#1;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_request();
		test_value_edges();
		test_bad_values();
		test_empty_block();
		test_unfinished();
		test_stray_cr();
		test_extreme_bytes();
		test_backpressure();
		test_random_messages();

		@(negedge clk);
		msg_ch.valid <= 1'b0;
		while (pending_lengths.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
